// ===== rtl/shaeng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shaeng_pkg: shared types, constants and functions of the SHA-256 engine
// Word and digest payloads, controller states, control bundles and the
// round functions of FIPS 180-4.
// ----------------------------------------------------------------------------
package shaeng_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_hi;
    logic [63:0] digest_mid_hi;
    logic [63:0] digest_mid_lo;
    logic [63:0] digest_lo;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RD_A,
    ST_RD_B,
    ST_SCHED,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PD_FIRST,
    PD_MARK,
    PD_FILL,
    PD_LEN_LO,
    PD_DONE
  } pad_t;

  // Write port and two read addresses of the schedule memory
  typedef struct packed {
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic [3:0]  raddr0;
    logic [3:0]  raddr1;
  } mem_req_t;

  // Controls from the sequencer to the round datapath
  typedef struct packed {
    logic       load_vars;
    logic       do_round;
    logic       add_hash;
    logic       init_hash;
    logic [5:0] round;
  } rnd_ctrl_t;

  localparam logic [31:0] MARK_WORD  = 32'h8000_0000;
  localparam logic [3:0]  LAST_SLOT  = 4'd15;
  localparam logic [3:0]  LEN_SLOT   = 4'd14;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] h_init(input logic [2:0] i);
    case (i)
      3'd0:    h_init = 32'h6a09e667;
      3'd1:    h_init = 32'hbb67ae85;
      3'd2:    h_init = 32'h3c6ef372;
      3'd3:    h_init = 32'ha54ff53a;
      3'd4:    h_init = 32'h510e527f;
      3'd5:    h_init = 32'h9b05688c;
      3'd6:    h_init = 32'h1f83d9ab;
      default: h_init = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] r);
    case (r)
      6'd0:  k_const = 32'h428a2f98;  6'd1:  k_const = 32'h71374491;
      6'd2:  k_const = 32'hb5c0fbcf;  6'd3:  k_const = 32'he9b5dba5;
      6'd4:  k_const = 32'h3956c25b;  6'd5:  k_const = 32'h59f111f1;
      6'd6:  k_const = 32'h923f82a4;  6'd7:  k_const = 32'hab1c5ed5;
      6'd8:  k_const = 32'hd807aa98;  6'd9:  k_const = 32'h12835b01;
      6'd10: k_const = 32'h243185be;  6'd11: k_const = 32'h550c7dc3;
      6'd12: k_const = 32'h72be5d74;  6'd13: k_const = 32'h80deb1fe;
      6'd14: k_const = 32'h9bdc06a7;  6'd15: k_const = 32'hc19bf174;
      6'd16: k_const = 32'he49b69c1;  6'd17: k_const = 32'hefbe4786;
      6'd18: k_const = 32'h0fc19dc6;  6'd19: k_const = 32'h240ca1cc;
      6'd20: k_const = 32'h2de92c6f;  6'd21: k_const = 32'h4a7484aa;
      6'd22: k_const = 32'h5cb0a9dc;  6'd23: k_const = 32'h76f988da;
      6'd24: k_const = 32'h983e5152;  6'd25: k_const = 32'ha831c66d;
      6'd26: k_const = 32'hb00327c8;  6'd27: k_const = 32'hbf597fc7;
      6'd28: k_const = 32'hc6e00bf3;  6'd29: k_const = 32'hd5a79147;
      6'd30: k_const = 32'h06ca6351;  6'd31: k_const = 32'h14292967;
      6'd32: k_const = 32'h27b70a85;  6'd33: k_const = 32'h2e1b2138;
      6'd34: k_const = 32'h4d2c6dfc;  6'd35: k_const = 32'h53380d13;
      6'd36: k_const = 32'h650a7354;  6'd37: k_const = 32'h766a0abb;
      6'd38: k_const = 32'h81c2c92e;  6'd39: k_const = 32'h92722c85;
      6'd40: k_const = 32'ha2bfe8a1;  6'd41: k_const = 32'ha81a664b;
      6'd42: k_const = 32'hc24b8b70;  6'd43: k_const = 32'hc76c51a3;
      6'd44: k_const = 32'hd192e819;  6'd45: k_const = 32'hd6990624;
      6'd46: k_const = 32'hf40e3585;  6'd47: k_const = 32'h106aa070;
      6'd48: k_const = 32'h19a4c116;  6'd49: k_const = 32'h1e376c08;
      6'd50: k_const = 32'h2748774c;  6'd51: k_const = 32'h34b0bcb5;
      6'd52: k_const = 32'h391c0cb3;  6'd53: k_const = 32'h4ed8aa4a;
      6'd54: k_const = 32'h5b9cca4f;  6'd55: k_const = 32'h682e6ff3;
      6'd56: k_const = 32'h748f82ee;  6'd57: k_const = 32'h78a5636f;
      6'd58: k_const = 32'h84c87814;  6'd59: k_const = 32'h8cc70208;
      6'd60: k_const = 32'h90befffa;  6'd61: k_const = 32'ha4506ceb;
      6'd62: k_const = 32'hbef9a3f7;  default: k_const = 32'hc67178f2;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_hash_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hash_engine_core: SHA-256 hash engine
// Streams a message in 32-bit big-endian words and returns its digest.
// ----------------------------------------------------------------------------
// A message arrives as 32-bit words on the word channel, first byte in bits
// 31:24. Every word but the last carries four bytes; the word flagged
// last_word carries byte_count bytes (0 to 4, larger counts act as 4) from
// the top. The engine pads the message itself (marker byte, zeros, 64-bit
// bit length, with an extra block when needed) and returns one 256-bit
// digest on the digest channel, H0 in the top half of digest_hi. A word
// that does not close a 512-bit block is written into the block memory.
// The sixteenth word of a block starts a compression (read and round
// states for rounds 0 to 15; read, second read, schedule and round states
// for rounds 16 to 63; a state to fold in the chaining value), shaped by
// the single block memory with two read ports that holds both the block
// and the rolling schedule; no word is taken meanwhile. After the last
// word, padding runs one or two more compressions, writing one word per
// cycle ahead of each, then the digest lands in an output register, which
// frees the engine for the next message while the digest waits to be taken.
// ----------------------------------------------------------------------------
module sha256_hash_engine_core
  import shaeng_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     word_valid,
  output logic     word_ready,
  input  in_word_t word,
  output logic     digest_valid,
  input  logic     digest_ready,
  output digest_t  digest
);

  mem_req_t         mem_req;
  rnd_ctrl_t        rnd;
  logic [31:0]      rdata0;
  logic [31:0]      rdata1;
  logic [31:0]      w_word;
  logic [7:0][31:0] hash_words;
  logic             out_free;
  logic             emit;

  // The output register may take a new digest when empty or being drained
  assign out_free = !digest_valid || digest_ready;

  shaeng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (word_valid),
    .in_word  (word),
    .in_ready (word_ready),
    .mem_req  (mem_req),
    .rdata0   (rdata0),
    .rdata1   (rdata1),
    .rnd      (rnd),
    .w_word   (w_word),
    .out_free (out_free),
    .emit     (emit)
  );

  shaeng_wmem u_wmem (
    .clk    (clk),
    .req    (mem_req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  shaeng_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (rnd),
    .w_word     (w_word),
    .hash_words (hash_words)
  );

  // Hold the digest until taken; the chaining value resets in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (emit) begin
      digest_valid <= 1'b1;
    end else if (digest_ready) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digest.digest_hi     <= {hash_words[0], hash_words[1]};
      digest.digest_mid_hi <= {hash_words[2], hash_words[3]};
      digest.digest_mid_lo <= {hash_words[4], hash_words[5]};
      digest.digest_lo     <= {hash_words[6], hash_words[7]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/shaeng_wmem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shaeng_wmem: block and schedule word memory
// 16 x 32 bits, one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module shaeng_wmem
  import shaeng_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata0,
  output logic [31:0] rdata1
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[req.raddr0];
    rdata1 <= mem[req.raddr1];
  end

endmodule
`default_nettype wire

// ===== rtl/shaeng_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shaeng_round: working variables, chaining value and one compression round
// Loads a..h from the chaining value, runs one round per strobe and folds
// the result back into the chaining value.
// ----------------------------------------------------------------------------
module shaeng_round
  import shaeng_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rnd_ctrl_t        ctrl,
  input  logic [31:0]      w_word,
  output logic [7:0][31:0] hash_words
);

  logic [31:0] v [8];
  logic [31:0] hash [8];
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(ctrl.round) + w_word;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_vars) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (ctrl.do_round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init_hash) begin
      for (int i = 0; i < 8; i++) hash[i] <= h_init(3'(i));
    end else if (ctrl.add_hash) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) hash_words[i] = hash[i];
  end

endmodule
`default_nettype wire

// ===== rtl/shaeng_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shaeng_ctrl: word intake, padding and round sequencer
// Writes words into the schedule memory, pads the final block, steps the
// memory reads for each round and computes extended schedule words.
// ----------------------------------------------------------------------------
module shaeng_ctrl
  import shaeng_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  in_word_t    in_word,
  output logic        in_ready,
  output mem_req_t    mem_req,
  input  logic [31:0] rdata0,
  input  logic [31:0] rdata1,
  output rnd_ctrl_t   rnd,
  output logic [31:0] w_word,
  input  logic        out_free,
  output logic        emit
);

  state_t      state;
  state_t      state_next;
  pad_t        pad_stage;
  pad_t        pad_next;
  logic [3:0]  pos;
  logic [63:0] bits;
  logic [5:0]  round;
  logic        msg_end;
  logic [31:0] pad_word;
  logic        need_mark;
  logic [31:0] x2;
  logic [31:0] x15;
  logic [31:0] w_reg;
  logic [31:0] w_next;

  logic        accept;
  logic        push;
  logic [31:0] push_word;
  logic        early;
  logic [2:0]  cnt_c;
  logic [31:0] last_merged;

  assign accept = (state == ST_IDLE) && in_valid;
  assign early  = (round < 6'd16);
  assign cnt_c  = (in_word.byte_count > 3'd4) ? 3'd4 : in_word.byte_count;
  assign w_next = ssig1(x2) + rdata0 + ssig0(x15) + rdata1;
  assign w_word = early ? rdata0 : w_reg;

  // Keep the valid top bytes of a short last word and place the marker below
  always_comb begin
    case (cnt_c)
      3'd0:    last_merged = 32'h8000_0000;
      3'd1:    last_merged = {in_word.data_word[31:24], 24'h80_0000};
      3'd2:    last_merged = {in_word.data_word[31:16], 16'h8000};
      3'd3:    last_merged = {in_word.data_word[31:8], 8'h80};
      default: last_merged = in_word.data_word;
    endcase
  end

  // Outputs of each state
  always_comb begin
    in_ready       = 1'b0;
    push           = 1'b0;
    push_word      = '0;
    pad_next       = pad_stage;
    emit           = 1'b0;
    mem_req.raddr0 = round[3:0];
    mem_req.raddr1 = round[3:0] + 4'd1;
    rnd.do_round   = 1'b0;
    rnd.add_hash   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        push      = in_valid && !in_word.last_word;
        push_word = in_word.data_word;
      end
      ST_PAD: begin
        push = 1'b1;
        case (pad_stage)
          PD_FIRST: begin
            push_word = pad_word;
            pad_next  = need_mark ? PD_MARK : PD_FILL;
          end
          PD_MARK: begin
            push_word = MARK_WORD;
            pad_next  = PD_FILL;
          end
          PD_FILL: begin
            if (pos == LEN_SLOT) begin
              push_word = bits[63:32];
              pad_next  = PD_LEN_LO;
            end else begin
              push_word = '0;
            end
          end
          PD_LEN_LO: begin
            push_word = bits[31:0];
            pad_next  = PD_DONE;
          end
          default: begin
            push      = 1'b0;
            push_word = '0;
          end
        endcase
      end
      ST_RD_A: begin
        // Early rounds read the block word; later ones fetch W[r-2], W[r-15]
        mem_req.raddr0 = early ? round[3:0] : round[3:0] - 4'd2;
        mem_req.raddr1 = round[3:0] + 4'd1;
      end
      ST_RD_B: begin
        // Fetch W[r-7] and W[r-16]
        mem_req.raddr0 = round[3:0] + 4'd9;
        mem_req.raddr1 = round[3:0];
      end
      ST_ROUND: rnd.do_round = 1'b1;
      ST_ADD:   rnd.add_hash = 1'b1;
      ST_EMIT:  emit = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    mem_req.we    = push || (state == ST_SCHED);
    mem_req.waddr = push ? pos : round[3:0];
    mem_req.wdata = push ? push_word : w_next;
    rnd.load_vars = push && (pos == LAST_SLOT);
    rnd.init_hash = emit;
    rnd.round     = round;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.last_word) begin
            state_next = ST_PAD;
          end else if (pos == LAST_SLOT) begin
            state_next = ST_RD_A;
          end
        end
      end
      ST_PAD: begin
        if (pos == LAST_SLOT) begin
          state_next = ST_RD_A;
        end
      end
      ST_RD_A:  state_next = early ? ST_ROUND : ST_RD_B;
      ST_RD_B:  state_next = ST_SCHED;
      ST_SCHED: state_next = ST_ROUND;
      ST_ROUND: state_next = (round == LAST_ROUND) ? ST_ADD : ST_RD_A;
      ST_ADD: begin
        if (!msg_end) begin
          state_next = ST_IDLE;
        end else if (pad_stage == PD_DONE) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pad_stage <= PD_DONE;
      pos       <= '0;
      bits      <= '0;
      round     <= '0;
      msg_end   <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        pos <= pos + 4'd1;
      end
      if (state == ST_PAD) begin
        pad_stage <= pad_next;
      end
      if (rnd.load_vars) begin
        round <= '0;
      end else if (rnd.do_round) begin
        round <= round + 6'd1;
      end
      if (accept && in_word.last_word) begin
        bits      <= bits + {58'd0, cnt_c, 3'b000};
        msg_end   <= 1'b1;
        pad_stage <= PD_FIRST;
      end else if (accept) begin
        bits <= bits + 64'd32;
      end
      if (emit) begin
        bits    <= '0;
        msg_end <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_word.last_word) begin
      pad_word  <= last_merged;
      need_mark <= (cnt_c == 3'd4);
    end
    if (state == ST_RD_B) begin
      x2  <= rdata0;
      x15 <= rdata1;
    end
    if (state == ST_SCHED) begin
      w_reg <= w_next;
    end
  end

endmodule
`default_nettype wire
